// ===== hw/rtl/itlv_pkg.sv =====
package itlv_pkg;

    localparam int MaxTokens = 512;
    localparam int SeenAw = $clog2(MaxTokens);
    localparam int SeenCw = $clog2(MaxTokens + 1);
    localparam int IndexCap = (MaxTokens - 1 < 511) ? (MaxTokens - 1) : 511;

    localparam logic [32:0] PosLimit = 33'h0_7FFF_FFFF;
    localparam logic [32:0] NegLimit = 33'h1_0000_0000 >> 1;
    localparam logic [3:0] CharSat = 4'd15;

    localparam logic [7:0] ChZero = 8'h30;
    localparam logic [7:0] ChNine = 8'h39;
    localparam logic [7:0] ChMinus = 8'h2D;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_FORMAT = 3'd1,
        ST_RANGE = 3'd2,
        ST_DUP = 3'd3,
        ST_FULL = 3'd4
    } t_status;

    // Classified token handed from the front part to the back part.
    typedef struct packed {
        logic [31:0] value;
        logic        parse_ok;
        t_status     status;
        logic        list_end;
    } t_token;

endpackage

// ===== hw/rtl/itlv_front.sv =====
module itlv_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_ch,
    input  logic            i_token_end,
    input  logic            i_list_end,
    output logic            o_tok_valid,
    input  logic            i_tok_ready,
    output itlv_pkg::t_token o_tok
);
    import itlv_pkg::*;

    logic [3:0]  r_count;
    logic        r_neg;
    logic        r_lz;
    logic        r_fbad;
    logic [32:0] r_mag;
    logic        r_rbad;

    logic [3:0]  n_count;
    logic        n_neg, n_lz, n_fbad, n_rbad;
    logic [32:0] n_mag;
    logic [36:0] mul;
    logic        is_digit, first_digit, has_digit;
    logic [32:0] limit;

    // Hold input while the queue is full and this char ends a token.
    assign o_ready = !i_token_end || i_tok_ready;
    assign o_tok_valid = i_valid && i_token_end;

    always_comb begin
        n_count = r_count;
        n_neg = r_neg;
        n_lz = r_lz;
        n_fbad = r_fbad;
        n_mag = r_mag;
        n_rbad = r_rbad;
        is_digit = (i_ch >= ChZero) && (i_ch <= ChNine);
        first_digit = (r_count < CharSat) && (r_count == {3'd0, r_neg});
        mul = {1'b0, r_mag, 3'd0} + {3'd0, r_mag, 1'b0} + {29'd0, i_ch - ChZero};
        if (r_count == 4'd0 && i_ch == ChMinus) begin
            n_neg = 1'b1;
        end else if (is_digit) begin
            if (first_digit) begin
                n_lz = (i_ch == ChZero);
            end else if (r_lz) begin
                n_fbad = 1'b1;
            end
            if (!r_rbad) begin
                if (mul > {4'd0, NegLimit}) begin
                    n_rbad = 1'b1;
                end else begin
                    n_mag = mul[32:0];
                end
            end
        end else begin
            n_fbad = 1'b1;
        end
        if (r_count < CharSat) begin
            n_count = r_count + 4'd1;
        end
        has_digit = n_count > {3'd0, n_neg};
        limit = n_neg ? NegLimit : PosLimit;
        o_tok.list_end = i_list_end;
        o_tok.value = n_neg ? (32'd0 - n_mag[31:0]) : n_mag[31:0];
        o_tok.parse_ok = 1'b0;
        if (n_fbad || !has_digit) begin
            o_tok.status = ST_FORMAT;
        end else if (n_rbad || n_mag > limit) begin
            o_tok.status = ST_RANGE;
        end else begin
            o_tok.status = ST_OK;
            o_tok.parse_ok = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_neg <= 1'b0;
            r_lz <= 1'b0;
            r_fbad <= 1'b0;
            r_mag <= '0;
            r_rbad <= 1'b0;
        end else if (i_valid && o_ready) begin
            if (i_token_end) begin
                r_count <= '0;
                r_neg <= 1'b0;
                r_lz <= 1'b0;
                r_fbad <= 1'b0;
                r_mag <= '0;
                r_rbad <= 1'b0;
            end else begin
                r_count <= n_count;
                r_neg <= n_neg;
                r_lz <= n_lz;
                r_fbad <= n_fbad;
                r_mag <= n_mag;
                r_rbad <= n_rbad;
            end
        end
    end
endmodule

// ===== hw/rtl/itlv_queue.sv =====
module itlv_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  itlv_pkg::t_token i_tok,
    output logic            o_valid,
    input  logic            i_ready,
    output itlv_pkg::t_token o_tok
);
    import itlv_pkg::*;

    t_token     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_tok = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== hw/rtl/itlv_back.sv =====
module itlv_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  itlv_pkg::t_token   i_tok,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_value,
    output logic [2:0]         o_status,
    output logic [8:0]         o_token_index,
    output logic               o_last,
    output logic               o_list_ok
);
    import itlv_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_CHK  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state            r_state;
    logic [31:0]       r_mem [MaxTokens];
    logic [31:0]       r_rd;
    logic [SeenCw-1:0] r_seen;
    logic [SeenCw-1:0] r_ptr;
    logic [SeenCw-1:0] r_tcount;
    logic              r_bad;
    logic              r_dup;
    t_token            r_tok;
    logic              r_rd_vld;
    logic              wr_en;
    t_status           fin;

    assign o_ready = r_state == S_IDLE;

    always_comb begin
        if (!r_tok.parse_ok) fin = r_tok.status;
        else if (r_dup) fin = ST_DUP;
        else if (r_seen >= SeenCw'(MaxTokens)) fin = ST_FULL;
        else fin = ST_OK;
    end

    assign wr_en = (r_state == S_CHK) && (fin == ST_OK);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_seen[SeenAw-1:0]] <= r_tok.value;
        end
        r_rd <= r_mem[r_ptr[SeenAw-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seen <= '0;
            r_tcount <= '0;
            r_bad <= 1'b0;
            r_ptr <= '0;
            r_dup <= 1'b0;
            r_rd_vld <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_tok <= i_tok;
                        r_ptr <= '0;
                        r_dup <= 1'b0;
                        r_rd_vld <= 1'b0;
                        r_state <= i_tok.parse_ok ? S_SCAN : S_CHK;
                    end
                end
                S_SCAN: begin
                    // Read one stored value per cycle; compare it in the next cycle.
                    if (r_rd_vld && r_rd == r_tok.value) r_dup <= 1'b1;
                    if (r_ptr < r_seen && !(r_rd_vld && r_rd == r_tok.value)) begin
                        r_ptr <= r_ptr + SeenCw'(1);
                        r_rd_vld <= 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                        if (r_ptr == r_seen || (r_rd_vld && r_rd == r_tok.value))
                            r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    o_valid <= 1'b1;
                    o_status <= fin;
                    o_value <= (fin == ST_OK) ? r_tok.value : 32'd0;
                    o_token_index <= (r_tcount < SeenCw'(IndexCap))
                        ? 9'(r_tcount) : 9'(IndexCap);
                    o_last <= r_tok.list_end;
                    o_list_ok <= r_tok.list_end && !r_bad && (fin == ST_OK);
                    if (r_tok.list_end) begin
                        r_seen <= '0;
                        r_tcount <= '0;
                        r_bad <= 1'b0;
                    end else begin
                        if (fin == ST_OK) r_seen <= r_seen + SeenCw'(1);
                        if (r_tcount < SeenCw'(MaxTokens)) r_tcount <= r_tcount + SeenCw'(1);
                        if (fin != ST_OK) r_bad <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/int32_token_list_validator_unit.sv =====
// Int32 token list validator.
// Input channel (i_valid/o_ready): one ASCII character per item, with
// i_token_end marking the last character of a token and i_list_end (valid
// only with i_token_end) marking the last token of the list.
// Output channel (o_valid/i_ready): one result per token: value, status
// (ok, bad format, out of range, duplicate, table full), token index,
// last flag and, on the last result, whether the whole list was ok.
// Characters that do not end a token are taken one per cycle by the front
// parser. A finished token enters a two-entry queue; the back unit then
// scans the stored values of the list for a well-formed token, one memory
// read per cycle, and takes no new token until its result is accepted.
// The result is registered in the check state, which a well-formed token
// reaches only after the scan; other tokens go straight to that state.
// Reset clears all parse and list state; the value table needs no clearing
// since only entries below the stored count are read. While the receiver
// stalls, the result holds, the queue fills and then token ends stall.
module int32_token_list_validator_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_ch,
    input  logic               i_token_end,
    input  logic               i_list_end,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_value,
    output logic [2:0]         o_status,
    output logic [8:0]         o_token_index,
    output logic               o_last,
    output logic               o_list_ok
);
    import itlv_pkg::*;

    t_token f_tok, q_tok;
    logic   f_valid, f_ready, q_valid, q_ready;

    // Front: parse and classify characters.
    itlv_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_ch(i_ch), .i_token_end(i_token_end), .i_list_end(i_list_end),
        .o_tok_valid(f_valid), .i_tok_ready(f_ready), .o_tok(f_tok)
    );

    // Decouple parsing from the duplicate scan.
    itlv_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready), .i_tok(f_tok),
        .o_valid(q_valid), .i_ready(q_ready), .o_tok(q_tok)
    );

    // Back: duplicate scan, store and report.
    itlv_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_tok(q_tok),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_value(o_value), .o_status(o_status), .o_token_index(o_token_index),
        .o_last(o_last), .o_list_ok(o_list_ok)
    );

    a_ok_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_list_ok |-> o_last && o_status == ST_OK)
        else $error("list_ok without last ok result");
    a_value_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_value == 32'sd0)
        else $error("nonzero value on error status");
    a_token_end_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_token_end |-> o_ready)
        else $error("plain character stalled");
endmodule
